/* rtl/dfr_pkg.sv */
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the delimited frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

	// Payload buffer depth seen by the frame limit
	localparam int BUF_DEPTH = 256;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;
	localparam int ADDR_W  = 2;
	localparam int CDATA_W = 9;
	localparam int RES_W   = 28;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	// Register indexes of the configuration port
	typedef enum logic [ADDR_W-1:0] {
		REG_HEADER    = 2'd0,
		REG_FOOTER1   = 2'd1,
		REG_FOOTER2   = 2'd2,
		REG_MAX_PAYLD = 2'd3
	} reg_idx_t;

	localparam logic [BYTE_W-1:0] HEADER_RST    = 8'h22;
	localparam logic [BYTE_W-1:0] FOOTER1_RST   = 8'h55;
	localparam logic [BYTE_W-1:0] FOOTER2_RST   = 8'h66;
	localparam logic [CNT_W-1:0]  MAX_PAYLD_RST = 9'd200;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_FOOTER  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] first_footer_byte;
		logic [BYTE_W-1:0] second_footer_byte;
		logic [CNT_W-1:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		logic              store_valid;
		logic [IDX_W-1:0]  store_index;
		logic [BYTE_W-1:0] store_data;
		logic              frame_done;
		logic [CNT_W-1:0]  frame_length;
		logic              frame_dropped;
	} res_t;

endpackage

`default_nettype wire

/* rtl/dfr_cfg.sv */
// ----------------------------------------------------------------------------
// dfr_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_cfg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [dfr_pkg::ADDR_W-1:0]    cfg_addr,
	input  wire [dfr_pkg::CDATA_W-1:0]   cfg_wdata,
	output dfr_pkg::cfg_t                cfg
);
	import dfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte        <= HEADER_RST;
			cfg_q.first_footer_byte  <= FOOTER1_RST;
			cfg_q.second_footer_byte <= FOOTER2_RST;
			cfg_q.max_payload        <= MAX_PAYLD_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_HEADER:    cfg_q.header_byte        <= cfg_wdata[BYTE_W-1:0];
				REG_FOOTER1:   cfg_q.first_footer_byte  <= cfg_wdata[BYTE_W-1:0];
				REG_FOOTER2:   cfg_q.second_footer_byte <= cfg_wdata[BYTE_W-1:0];
				REG_MAX_PAYLD: cfg_q.max_payload        <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/dfr_parse.sv */
// ----------------------------------------------------------------------------
// dfr_parse
// Frame phase tracker and payload counter; computes one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parse (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire [dfr_pkg::BYTE_W-1:0]  rx_byte,
	input  wire dfr_pkg::cfg_t         cfg,
	output dfr_pkg::res_t              res
);
	import dfr_pkg::*;

	phase_t           phase_q, phase_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [CNT_W-1:0] limit;

	// limit = min(max_payload, BUF_DEPTH)
	always_comb begin
		limit = cfg.max_payload;
		if (int'(cfg.max_payload) > BUF_DEPTH) begin
			limit = CNT_W'(BUF_DEPTH);
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		res       = '0;
		case (phase_q)
			PH_PAYLOAD: begin
				if (rx_byte == cfg.first_footer_byte) begin
					phase_nxt = PH_FOOTER;
				end else if (count_q >= limit) begin
					res.frame_dropped = 1'b1;
					phase_nxt         = PH_HUNT;
				end else begin
					res.store_valid = 1'b1;
					res.store_index = count_q[IDX_W-1:0];
					res.store_data  = rx_byte;
					count_nxt       = count_q + CNT_W'(1);
				end
			end
			PH_FOOTER: begin
				if (rx_byte == cfg.second_footer_byte) begin
					res.frame_done   = 1'b1;
					res.frame_length = count_q;
				end else begin
					res.frame_dropped = 1'b1;
				end
				phase_nxt = PH_HUNT;
			end
			default: begin
				phase_nxt = PH_HUNT;
				if (rx_byte == cfg.header_byte) begin
					phase_nxt = PH_PAYLOAD;
					count_nxt = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/delimited_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// delimited_frame_receiver_top
// Byte stream frame parser: header, payload, first footer, second footer.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result per
// byte: a payload buffer write, a frame-done pulse with the payload length, a
// drop flag, or all zeros. Throughput is one byte per clock while m_tready
// does not stall the output; each byte passes the input register and then the
// result register, with the phase and count update sitting between them. The
// output register lets a new byte enter while a result waits for m_tready.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and must only
// change while no byte is in flight.
`default_nettype none

module delimited_frame_receiver_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [dfr_pkg::ADDR_W-1:0]    cfg_addr,
	input  wire [dfr_pkg::CDATA_W-1:0]   cfg_wdata,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [dfr_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [0] store_valid, [8:1] store_index, [16:9] store_data, [17] frame_done,
	// [26:18] frame_length, [27] frame_dropped, upper bits zero
	output logic [dfr_pkg::TDATA_W-1:0]  m_tdata
);
	import dfr_pkg::*;

	cfg_t              cfg;
	res_t              res;
	res_t              res_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dfr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, res_q.frame_dropped, res_q.frame_length,
		res_q.frame_done, res_q.store_data, res_q.store_index, res_q.store_valid};

	// a result reports at most one kind of event
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones({res_q.store_valid, res_q.frame_done,
			res_q.frame_dropped}) <= 1))
		else $error("more than one event in a result");

	// completed frame never longer than the buffer
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.frame_done) |-> (int'(res_q.frame_length) <= BUF_DEPTH))
		else $error("frame length beyond buffer depth");

	// input is only held off when both stages are full and the output stalls
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
